FILE: hw/rtl/lrupr_pkg.sv
package lrupr_pkg;

	// Default sizing
	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	// Field widths fixed by the interface
	localparam int CFG_W     = 5;
	localparam int IDX_OUT_W = 4;
	localparam int TOTAL_W   = 32;

	// Frame count after reset
	localparam logic [CFG_W-1:0] FIU_RESET = CFG_W'(16);

	// Saturation value of the running totals
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// Outcome of the frame lookup, handed from select to update
	typedef struct packed {
		logic hit;        // page resident in an active frame
		logic evict;      // no empty active frame, LRU victim replaced
		logic limit_all;  // filling an empty frame: every valid frame ages
	} sel_flags_t;

endpackage

FILE: hw/rtl/lrupr_if.sv
// Request channel
interface lrupr_req_if #(
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;
	logic                 last_of_run;

	modport source (output valid, output page_number, output last_of_run, input ready);
	modport sink   (input valid, input page_number, input last_of_run, output ready);
endinterface

// Result channel
interface lrupr_rsp_if #(
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic [lrupr_pkg::IDX_OUT_W-1:0]   frame_index;
	logic                              evicted;
	logic [PAGE_BITS-1:0]              evicted_page;
	logic [lrupr_pkg::TOTAL_W-1:0]     hit_total;
	logic [lrupr_pkg::TOTAL_W-1:0]     fault_total;
	logic                              run_end;

	modport source (output valid, output hit, output frame_index, output evicted,
		output evicted_page, output hit_total, output fault_total, output run_end,
		input ready);
	modport sink (input valid, input hit, input frame_index, input evicted,
		input evicted_page, input hit_total, input fault_total, input run_end,
		output ready);
endinterface

FILE: hw/rtl/lrupr_select.sv
// Frame lookup: parallel tag compare, first empty frame and LRU victim
module lrupr_select #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
	parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic [lrupr_pkg::CFG_W-1:0] frames_in_use,
	input  logic [PAGE_BITS-1:0]        page,
	input  logic [PAGE_BITS-1:0]        tags [FRAMES],
	input  logic [FRAMES-1:0]           valid,
	input  logic [IDX_W-1:0]            ranks [FRAMES],
	output lrupr_pkg::sel_flags_t       flags,
	output logic [IDX_W-1:0]            pos,
	output logic [IDX_W-1:0]            limit
);

	logic [FRAMES-1:0] active;
	logic [FRAMES-1:0] match;
	logic [FRAMES-1:0] empty;
	logic [FRAMES-1:0] is_max;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  empty_idx;
	logic [IDX_W-1:0]  victim_idx;

	// Per-frame lanes: a count of 0 still keeps frame 0 active
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			active[i] = (i == 0) || (i < int'(frames_in_use));
			match[i]  = active[i] && valid[i] && (tags[i] == page);
			empty[i]  = active[i] && !valid[i];
			is_max[i] = active[i];
			for (int j = 0; j < FRAMES; j++) begin
				if (active[j] && (ranks[j] > ranks[i])) begin
					is_max[i] = 1'b0;
				end
			end
		end
	end

	// Lowest-numbered candidate of each kind
	always_comb begin
		hit_idx    = '0;
		empty_idx  = '0;
		victim_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (empty[i]) begin
				empty_idx = IDX_W'(i);
			end
			if (is_max[i]) begin
				victim_idx = IDX_W'(i);
			end
		end
	end

	// Pick the frame and the aging limit
	always_comb begin
		flags.hit       = |match;
		flags.limit_all = !flags.hit && (|empty);
		flags.evict     = !flags.hit && !(|empty);
		if (flags.hit) begin
			pos = hit_idx;
		end else if (flags.limit_all) begin
			pos = empty_idx;
		end else begin
			pos = victim_idx;
		end
		limit = ranks[pos];
	end

endmodule

FILE: hw/rtl/lru_page_replacement.sv
// LRU page replacement over a fully associative set of page frames.
// Channels: req (sink) carries page_number and last_of_run; rsp (source)
// returns one result per request: hit, frame_index, evicted, evicted_page,
// hit_total, fault_total and run_end. A transaction moves on a rising clk
// edge with valid and ready both high. cfg_we/cfg_wdata write frames_in_use
// (0 acts as 1, above FRAMES acts as FRAMES); write it only while idle.
// Steps: compare (parallel tag compare and victim pick), then update
// (rank update, page table write, result load) into the output register.
// A new request is taken while idle or as the previous one leaves update,
// not during its compare. The page table is a synchronous RAM read at the
// chosen frame in the compare cycle; the evicted page arrives in the update cycle.
// Reset (arst_n low): all frames empty, ranks and totals zero,
// frames_in_use = 16; no clearing pass is needed. A request with
// last_of_run set is answered, then frames and totals clear.
// If rsp stalls, the finished result holds in the output register; one more
// request is taken and processed up to the update cycle, where it waits.
module lru_page_replacement #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
	lrupr_req_if.sink                   req,
	lrupr_rsp_if.source                 rsp
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int OUT_W  = lrupr_pkg::IDX_OUT_W;
	localparam int TOT_W  = lrupr_pkg::TOTAL_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_S1   = 2'd1;
	localparam logic [1:0] ST_S2   = 2'd2;

	logic [1:0]                  st_q;
	logic [lrupr_pkg::CFG_W-1:0] fiu_q;

	// Frame state
	logic [PAGE_BITS-1:0] tag_q  [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [IDX_W-1:0]     rank_q [FRAMES];
	logic [TOT_W-1:0]     hit_cnt_q;
	logic [TOT_W-1:0]     fault_cnt_q;
	logic [PAGE_BITS-1:0] page_mem [FRAMES];

	// Request in compare stage
	logic [PAGE_BITS-1:0] page_s1;
	logic                 last_s1;

	// Request in update stage
	lrupr_pkg::sel_flags_t flags_s2;
	logic [IDX_W-1:0]      pos_s2;
	logic [IDX_W-1:0]      limit_s2;
	logic [PAGE_BITS-1:0]  page_s2;
	logic                  last_s2;
	logic [PAGE_BITS-1:0]  page_rd_s2;

	// Output register
	logic                 out_valid_q;
	logic                 hit_q;
	logic [OUT_W-1:0]     frame_index_q;
	logic                 evicted_q;
	logic [PAGE_BITS-1:0] evicted_page_q;
	logic [TOT_W-1:0]     hit_total_q;
	logic [TOT_W-1:0]     fault_total_q;
	logic                 run_end_q;

	lrupr_pkg::sel_flags_t sel_flags;
	logic [IDX_W-1:0]      sel_pos;
	logic [IDX_W-1:0]      sel_limit;
	logic                  advance;
	logic                  accept;
	logic [TOT_W-1:0]      hit_nxt;
	logic [TOT_W-1:0]      fault_nxt;
	logic [IDX_W+OUT_W-1:0] pos_ext;

	// Handshake
	assign advance   = (st_q == ST_S2) && (!out_valid_q || rsp.ready);
	assign req.ready = (st_q == ST_IDLE) || advance;
	assign accept    = req.valid && req.ready;

	lrupr_select #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.IDX_W     (IDX_W)
	) u_lrupr_select (
		.frames_in_use (fiu_q),
		.page          (page_s1),
		.tags          (tag_q),
		.valid         (valid_q),
		.ranks         (rank_q),
		.flags         (sel_flags),
		.pos           (sel_pos),
		.limit         (sel_limit)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_S1;
					end
				end
				ST_S1: begin
					st_q <= ST_S2;
				end
				ST_S2: begin
					if (advance) begin
						st_q <= accept ? ST_S1 : ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= lrupr_pkg::FIU_RESET;
		end else if (cfg_we) begin
			fiu_q <= cfg_wdata;
		end
	end

	// Stage registers (payload only)
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= req.page_number;
			last_s1 <= req.last_of_run;
		end
		if (st_q == ST_S1) begin
			flags_s2   <= sel_flags;
			pos_s2     <= sel_pos;
			limit_s2   <= sel_limit;
			page_s2    <= page_s1;
			last_s2    <= last_s1;
			page_rd_s2 <= page_mem[sel_pos];
		end
	end

	// Page table RAM and tag lanes, written on a fault
	always_ff @(posedge clk) begin
		if (advance && !flags_s2.hit) begin
			page_mem[pos_s2] <= page_s2;
			tag_q[pos_s2]    <= page_s2;
		end
	end

	// Saturating totals for this request
	always_comb begin
		hit_nxt   = hit_cnt_q;
		fault_nxt = fault_cnt_q;
		if (flags_s2.hit) begin
			if (hit_cnt_q != lrupr_pkg::TOTAL_MAX) begin
				hit_nxt = hit_cnt_q + TOT_W'(1);
			end
		end else if (fault_cnt_q != lrupr_pkg::TOTAL_MAX) begin
			fault_nxt = fault_cnt_q + TOT_W'(1);
		end
	end

	// Rank aging, valid bits and totals; end of run clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance) begin
			if (last_s2) begin
				valid_q     <= '0;
				hit_cnt_q   <= '0;
				fault_cnt_q <= '0;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= '0;
				end
			end else begin
				hit_cnt_q   <= hit_nxt;
				fault_cnt_q <= fault_nxt;
				for (int i = 0; i < FRAMES; i++) begin
					if (IDX_W'(i) == pos_s2) begin
						rank_q[i]  <= '0;
						valid_q[i] <= 1'b1;
					end else if (valid_q[i] && (flags_s2.limit_all || rank_q[i] < limit_s2)) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
			end
		end
	end

	assign pos_ext = {{OUT_W{1'b0}}, pos_s2};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q          <= flags_s2.hit;
			frame_index_q  <= pos_ext[OUT_W-1:0];
			evicted_q      <= flags_s2.evict;
			evicted_page_q <= flags_s2.evict ? page_rd_s2 : '0;
			hit_total_q    <= hit_nxt;
			fault_total_q  <= fault_nxt;
			run_end_q      <= last_s2;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.frame_index  = frame_index_q;
	assign rsp.evicted      = evicted_q;
	assign rsp.evicted_page = evicted_page_q;
	assign rsp.hit_total    = hit_total_q;
	assign rsp.fault_total  = fault_total_q;
	assign rsp.run_end      = run_end_q;

endmodule

FILE: hw/rtl/lrupr_checker.sv
// Port-level checks for the LRU page replacement block
module lrupr_checker #(
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic                              hit,
	input logic [lrupr_pkg::IDX_OUT_W-1:0]   frame_index,
	input logic                              evicted,
	input logic [PAGE_BITS-1:0]              evicted_page,
	input logic [lrupr_pkg::TOTAL_W-1:0]     hit_total,
	input logic [lrupr_pkg::TOTAL_W-1:0]     fault_total,
	input logic                              run_end
);

	localparam int SUM_W = lrupr_pkg::TOTAL_W + 1;

	logic             req_acc;
	logic             rsp_acc;
	logic [2:0]       pend_q;
	logic [SUM_W-1:0] sum_now;
	logic [SUM_W-1:0] prev_sum_q;
	logic             prev_sat_q;
	logic             prev_end_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;
	assign sum_now = SUM_W'(hit_total) + SUM_W'(fault_total);

	// Requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 3'd1;
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	// Totals of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sum_q <= '0;
			prev_sat_q <= 1'b0;
			prev_end_q <= 1'b1;
		end else if (rsp_acc) begin
			prev_sum_q <= sum_now;
			prev_sat_q <= (hit_total == lrupr_pkg::TOTAL_MAX) ||
				(fault_total == lrupr_pkg::TOTAL_MAX);
			prev_end_q <= run_end;
		end
	end

	// One request in flight through the compare stage at a time
	a_one_in_compare: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while compare stage busy");

	// A result only answers a request, and at most two are held
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid |-> pend_q != 3'd0) and (pend_q <= 3'd2))
		else $error("result count does not follow requests");

	// Each result counts exactly one more hit or fault in its run
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && (prev_end_q || !prev_sat_q) |->
			sum_now == (prev_end_q ? SUM_W'(1) : prev_sum_q + SUM_W'(1)))
		else $error("running totals did not advance by one");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(frame_index) &&
			$stable(evicted) && $stable(evicted_page) && $stable(hit_total) &&
			$stable(fault_total) && $stable(run_end))
		else $error("result changed while stalled");

endmodule

bind lru_page_replacement lrupr_checker #(
	.PAGE_BITS (PAGE_BITS)
) u_lrupr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.hit          (rsp.hit),
	.frame_index  (rsp.frame_index),
	.evicted      (rsp.evicted),
	.evicted_page (rsp.evicted_page),
	.hit_total    (rsp.hit_total),
	.fault_total  (rsp.fault_total),
	.run_end      (rsp.run_end)
);

FILE: sim/tb_lru_page_replacement.sv
module tb_lru_page_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NFRAMES        = lrupr_pkg::FRAMES_DEF;
	localparam int PB             = lrupr_pkg::PAGE_BITS_DEF;
	localparam int CFG_W          = lrupr_pkg::CFG_W;
	localparam int IDX_OUT_W      = lrupr_pkg::IDX_OUT_W;
	localparam int TOTAL_W        = lrupr_pkg::TOTAL_W;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = lrupr_pkg::TOTAL_MAX;
	localparam logic [CFG_W-1:0]   FIU_RESET = lrupr_pkg::FIU_RESET;
	localparam int RANDOM_ITEMS   = 450;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	localparam int DIR_ROWS       = 23;

	// One response transaction, laid out field by field
	typedef struct packed {
		logic                 hit;
		logic [IDX_OUT_W-1:0] frame_index;
		logic                 evicted;
		logic [PB-1:0]        evicted_page;
		logic [TOTAL_W-1:0]   hit_total;
		logic [TOTAL_W-1:0]   fault_total;
		logic                 run_end;
	} lru_result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		logic [PB-1:0]  page;
		logic           last;
		logic [CFG_W-1:0] fiu;
		bit             known;  // expected result given in the row
		lru_result_t    want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lrupr_req_if #(.PAGE_BITS(PB)) req_ch ();
	lrupr_rsp_if #(.PAGE_BITS(PB)) rsp_ch ();

	lru_page_replacement #(
		.FRAMES   (NFRAMES),
		.PAGE_BITS(PB)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// Directed rows: reset behavior, extremes of page and frame count,
	// end of run, frame count lowered mid-run and raised again
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{ROW_REQ, 16'h0000, 1'b0, 5'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0, 32'd0, 32'd1, 1'b0}},
		'{ROW_REQ, 16'hFFFF, 1'b0, 5'd0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0, 32'd0, 32'd2, 1'b0}},
		'{ROW_REQ, 16'h0000, 1'b0, 5'd0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0, 32'd1, 32'd2, 1'b0}},
		'{ROW_REQ, 16'hFFFF, 1'b1, 5'd0, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0, 32'd2, 32'd2, 1'b1}},
		'{ROW_REQ, 16'hFFFF, 1'b0, 5'd0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0, 32'd0, 32'd1, 1'b0}},
		// zero frames acts as one frame
		'{ROW_CFG, 16'h0000, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h1234, 1'b0, 5'd0, 1'b1,
			'{1'b0, 4'd0, 1'b1, 16'hFFFF, 32'd0, 32'd2, 1'b0}},
		'{ROW_REQ, 16'h1234, 1'b0, 5'd0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0, 32'd1, 32'd2, 1'b0}},
		'{ROW_REQ, 16'hA5A5, 1'b1, 5'd0, 1'b1,
			'{1'b0, 4'd0, 1'b1, 16'h1234, 32'd1, 32'd3, 1'b1}},
		// above the frame count acts as all frames
		'{ROW_CFG, 16'h0000, 1'b0, 5'd31, 1'b0, '0},
		'{ROW_REQ, 16'h0001, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h0002, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h0003, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h0004, 1'b0, 5'd0, 1'b0, '0},
		// shrink mid-run: frames 2 and up are ignored but keep aging
		'{ROW_CFG, 16'h0000, 1'b0, 5'd2, 1'b0, '0},
		'{ROW_REQ, 16'h0003, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h0004, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h0001, 1'b0, 5'd0, 1'b0, '0},
		// grow again: frames 2 and up take part in the lookup again
		'{ROW_CFG, 16'h0000, 1'b0, 5'd16, 1'b0, '0},
		'{ROW_REQ, 16'h0003, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h5555, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h8000, 1'b0, 5'd0, 1'b0, '0},
		'{ROW_REQ, 16'h7FFF, 1'b1, 5'd0, 1'b0, '0}
	};

	// Frame table mirror
	logic [PB-1:0]    mdl_page  [NFRAMES];
	bit               mdl_valid [NFRAMES];
	int unsigned      mdl_rank  [NFRAMES];
	logic [TOTAL_W-1:0] mdl_hits;
	logic [TOTAL_W-1:0] mdl_faults;
	logic [CFG_W-1:0] mdl_fiu;

	lru_result_t expected_q [$];
	int  fail_count;
	bit  steady_flow;   // no idling on either side while set
	int  idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void lru_clear();
		for (int i = 0; i < NFRAMES; i++) begin
			mdl_page[i]  = '0;
			mdl_valid[i] = 1'b0;
			mdl_rank[i]  = 0;
		end
		mdl_hits   = '0;
		mdl_faults = '0;
	endfunction

	// Valid frames younger than lim age by one; frame f becomes most recent
	function automatic void lru_age(int f, int unsigned lim);
		for (int i = 0; i < NFRAMES; i++)
			if (mdl_valid[i] && i != f && mdl_rank[i] < lim)
				mdl_rank[i]++;
		mdl_rank[f] = 0;
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] v);
		return (v == TOTAL_MAX) ? v : v + 1'b1;
	endfunction

	// Lookup, fill or evict, then update totals
	function automatic lru_result_t lru_predict(logic [PB-1:0] page, logic last);
		int          active;
		int          pos;
		bit          found;
		bit          empty;
		int unsigned oldest;
		lru_result_t r;
		r      = '0;
		active = (mdl_fiu == 0) ? 1 : ((mdl_fiu > NFRAMES) ? NFRAMES : int'(mdl_fiu));
		found  = 1'b0;
		empty  = 1'b0;
		pos    = 0;
		for (int i = 0; i < active; i++)
			if (!found && mdl_valid[i] && mdl_page[i] == page) begin
				found = 1'b1;
				pos   = i;
			end
		if (found) begin
			mdl_hits = sat_inc(mdl_hits);
			lru_age(pos, mdl_rank[pos]);
		end else begin
			for (int i = 0; i < active; i++)
				if (!empty && !mdl_valid[i]) begin
					empty = 1'b1;
					pos   = i;
				end
			if (empty) begin
				lru_age(pos, 32'hFFFF_FFFF);
				mdl_valid[pos] = 1'b1;
			end else begin
				// oldest active frame, lowest index on a tie
				oldest = mdl_rank[0];
				pos    = 0;
				for (int i = 1; i < active; i++)
					if (mdl_rank[i] > oldest) begin
						oldest = mdl_rank[i];
						pos    = i;
					end
				r.evicted      = 1'b1;
				r.evicted_page = mdl_page[pos];
				lru_age(pos, oldest);
			end
			mdl_page[pos] = page;
			mdl_faults    = sat_inc(mdl_faults);
		end
		r.hit         = found;
		r.frame_index = IDX_OUT_W'(pos);
		r.hit_total   = mdl_hits;
		r.fault_total = mdl_faults;
		r.run_end     = last;
		if (last)
			lru_clear();
		return r;
	endfunction

	function automatic string result_str(lru_result_t r);
		return $sformatf("hit=%0b frame=%0d evicted=%0b page=%h hits=%0d faults=%0d end=%0b",
			r.hit, r.frame_index, r.evicted, r.evicted_page, r.hit_total, r.fault_total,
			r.run_end);
	endfunction

	function automatic void check_result(lru_result_t got);
		lru_result_t want;
		if (expected_q.size() == 0) begin
			if (fail_count < REPORT_LIMIT)
				$display("unexpected response: %s", result_str(got));
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		if (got !== want) begin
			if (fail_count < REPORT_LIMIT) begin
				$display("response mismatch, expected: %s", result_str(want));
				$display("                   actual:   %s", result_str(got));
			end
			fail_count++;
		end
	endfunction

	// One request transaction; the sender may idle before it
	task automatic send_req(input logic [PB-1:0] page, input logic last, input bit known,
		input lru_result_t want);
		int          gap;
		lru_result_t pred;
		gap = steady_flow ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.page_number <= page;
		req_ch.last_of_run <= last;
		do @(posedge clk); while (!req_ch.ready);
		pred = lru_predict(page, last);
		expected_q.push_back(known ? want : pred);
	endtask

	// Frame count write, only once every response is back
	task automatic write_fiu(input logic [CFG_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		mdl_fiu = value;
	endtask

	// Response side with random stalls
	initial begin : rsp_drain
		int          stall;
		lru_result_t got;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got = '{rsp_ch.hit, rsp_ch.frame_index, rsp_ch.evicted, rsp_ch.evicted_page,
				rsp_ch.hit_total, rsp_ch.fault_total, rsp_ch.run_end};
			check_result(got);
		end
	end

	// Watchdog: cycles without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_lru_page_replacement: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] fiu_val;
		logic [PB-1:0]    pool_base;
		logic [PB-1:0]    page;
		logic             last;
		int               act;
		int               pool_size;
		int               phase_len;
		int               sent;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.page_number = '0;
		req_ch.last_of_run = 1'b0;
		steady_flow        = 1'b0;
		fail_count         = 0;
		mdl_fiu            = FIU_RESET;
		lru_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_fiu(directed_rows[i].fiu);
			else
				send_req(directed_rows[i].page, directed_rows[i].last, directed_rows[i].known,
					directed_rows[i].want);
		end

		// random phases: a frame count, then requests over a small working set
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0:       fiu_val = 5'd0;
				1:       fiu_val = 5'd1;
				2:       fiu_val = 5'd16;
				3:       fiu_val = CFG_W'($urandom_range(17, 31));
				default: fiu_val = CFG_W'($urandom_range(2, 15));
			endcase
			write_fiu(fiu_val);
			act         = (fiu_val == 0) ? 1 : ((fiu_val > NFRAMES) ? NFRAMES : int'(fiu_val));
			pool_size   = act + $urandom_range(0, 4);
			pool_base   = PB'($urandom);
			phase_len   = $urandom_range(20, 60);
			steady_flow = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				// mostly working-set pages, some noise pages
				if ($urandom_range(0, 19) == 0)
					page = PB'($urandom);
				else
					page = pool_base + PB'($urandom_range(0, pool_size - 1));
				last = ($urandom_range(0, 39) == 0);
				send_req(page, last, 1'b0, '0);
				sent++;
			end
		end
		steady_flow = 1'b0;
		req_ch.valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_lru_page_replacement: PASS");
		else
			$display("tb_lru_page_replacement: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_if.sv
hw/rtl/lrupr_select.sv
hw/rtl/lru_page_replacement.sv
hw/rtl/lrupr_checker.sv
sim/tb_lru_page_replacement.sv
